>>> hw/rtl/mstsched_pkg.sv
// Package for the multiplexed soft timer scheduler: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package mstsched_pkg;
   localparam int SlotCount   = 8;
   localparam int SourceCount = 3;
   localparam int FifoDepth   = 16;
   localparam int SlotW  = $clog2(SlotCount);
   localparam int SrcW   = 2;
   localparam int FptrW  = $clog2(FifoDepth);
   localparam int FillW  = $clog2(FifoDepth + 1);
   localparam int FaddrW = $clog2(SourceCount * FifoDepth);
   localparam int FentW  = 64 + 36;
   // slot record: in_use, active, source, period, count, start, flags, words
   localparam int SlotRecW = 1 + 1 + SrcW + 32 + 32 + 64 + 5 + 32 + 32;

   localparam logic [2:0] OpTick  = 3'd0;
   localparam logic [2:0] OpOpen  = 3'd1;
   localparam logic [2:0] OpStart = 3'd2;
   localparam logic [2:0] OpStop  = 3'd3;
   localparam logic [2:0] OpClose = 3'd4;
   localparam logic [2:0] OpRead  = 3'd5;
   localparam logic [2:0] OpDrain = 3'd6;

   localparam logic [2:0] StOk      = 3'd0;
   localparam logic [2:0] StNoFree  = 3'd1;
   localparam logic [2:0] StBadSlot = 3'd2;
   localparam logic [2:0] StBadPer  = 3'd3;
   localparam logic [2:0] StEmpty   = 3'd4;

   localparam logic [1:0] KindAck   = 2'd0;
   localparam logic [1:0] KindImm   = 2'd1;
   localparam logic [1:0] KindDrain = 2'd2;

   typedef struct packed {
      logic              in_use;
      logic              active;
      logic [SrcW-1:0]   source;
      logic [31:0]       period;
      logic [31:0]       count;
      logic [63:0]       start;
      logic [4:0]        flags;
      logic [31:0]       word0;
      logic [31:0]       word1;
   } slot_rec_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic        cb;
      logic [63:0] elapsed;
      logic [31:0] word;
      logic        sr;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_EVAL, S_DIV, S_CB, S_WRITE, S_DRD, S_DOUT, S_OUT
   } state_type;
endpackage

>>> hw/rtl/mstsched_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mstsched_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/mstsched_div.sv
// Serial 64 by 32 bit unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module mstsched_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[31:0], q_ff[63]};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; n_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; n_ff <= n_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   // zero divisor gives zero, as a slot without period reads
   assign done = done_ff;
   assign quotient = (d_ff == 32'd0) ? 64'd0 : q_ff;
endmodule

>>> hw/rtl/multiplexed_soft_timer_scheduler_top.sv
// Top level of the multiplexed soft timer scheduler; uses mstsched_pkg, _ram, _div.
// Start, stop, close and read run a serial divide of the source count by the slot period.
// Tick: read-modify-write walk over the slot RAM; an expiring slot adds a divide and its
// callbacks, and output stalls can hold the walk. One item at a time.
// Reset clears control state and slot valid bits; FIFO RAM is not cleared (read after write).
`timescale 1ns / 1ps
module multiplexed_soft_timer_scheduler_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // operation[2:0], block_index[4:3], slot[7:5], period[39:8], one_shot[40],
   // first_enable[41], first_immediate[42], second_enable[43],
   // second_immediate[44], first_user_word[76:45], second_user_word[108:77]
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[2:0], kind[4:3], event_slot[7:5], callback_number[8],
   // elapsed[72:9], user_word[104:73], service_request[105]
   output logic [111:0]  rsp_tdata,
   output logic          rsp_tlast
);
   localparam int SW = mstsched_pkg::SlotW;
   localparam int SlotCountFix = mstsched_pkg::SlotCount;

   mstsched_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [111:0] req_ff, req_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic cb_ff, cb_in, sr_ff, sr_in;
   logic [63:0] el_ff, el_in;
   logic [63:0] cnt_ff [mstsched_pkg::SourceCount];
   logic [63:0] cnt_in [mstsched_pkg::SourceCount];
   logic [SlotCountFix-1:0] inuse_ff, inuse_in;
   logic [mstsched_pkg::FptrW-1:0] rp_ff [mstsched_pkg::SourceCount];
   logic [mstsched_pkg::FptrW-1:0] rp_in [mstsched_pkg::SourceCount];
   logic [mstsched_pkg::FptrW-1:0] wp_ff [mstsched_pkg::SourceCount];
   logic [mstsched_pkg::FptrW-1:0] wp_in [mstsched_pkg::SourceCount];
   logic [mstsched_pkg::FillW-1:0] fill_ff [mstsched_pkg::SourceCount];
   logic [mstsched_pkg::FillW-1:0] fill_in [mstsched_pkg::SourceCount];
   mstsched_pkg::slot_rec_type rec_ff, rec_in, rec_rd;
   mstsched_pkg::rsp_type out_ff, out_in;
   logic outv_ff, outv_in;

   // request fields
   logic [2:0] op;
   logic [1:0] src;
   logic [2:0] slot_f;
   logic [31:0] period;
   assign op = req_ff[2:0];
   assign src = req_ff[4:3];
   assign slot_f = req_ff[7:5];
   assign period = req_ff[39:8];

   // slot RAM
   logic s_we;
   logic [SW-1:0] s_raddr;
   logic [mstsched_pkg::SlotRecW-1:0] s_rdata;
   mstsched_ram #(.Width(mstsched_pkg::SlotRecW), .Depth(mstsched_pkg::SlotCount)) u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(idx_ff), .wr_data(rec_ff),
      .rd_addr(s_raddr), .rd_data(s_rdata));
   // entries whose valid bit is clear read as cleared
   assign rec_rd = inuse_ff[idx_ff] ? mstsched_pkg::slot_rec_type'(s_rdata) : '0;

   // FIFO RAM
   logic f_we;
   logic [mstsched_pkg::FaddrW-1:0] f_waddr, f_raddr;
   logic [mstsched_pkg::FentW-1:0] f_wdata, f_rdata;
   mstsched_ram #(.Width(mstsched_pkg::FentW),
                  .Depth(mstsched_pkg::SourceCount * mstsched_pkg::FifoDepth)) u_fifo (
      .clock(clock), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
      .rd_addr(f_raddr), .rd_data(f_rdata));

   // divider, loaded from the slot record being read
   logic d_start, d_done;
   logic [63:0] d_q, d_dividend;
   mstsched_div u_div (.clock(clock), .reset(reset), .start(d_start),
      .dividend(d_dividend), .divisor(rec_rd.period), .done(d_done), .quotient(d_q));
   assign d_dividend = cnt_ff[rec_rd.source];

   // lowest free slot
   logic free_found;
   logic [SW-1:0] free_idx;
   always_comb begin
      free_found = 1'b0; free_idx = '0;
      for (int i = SlotCountFix - 1; i >= 0; i--)
         if (!inuse_ff[i]) begin
            free_found = 1'b1; free_idx = SW'(i);
         end
   end

   logic src_ok;
   assign src_ok = {30'd0, src} < mstsched_pkg::SourceCount;

   function automatic logic [mstsched_pkg::FaddrW-1:0] faddr(input logic [1:0] s,
                                                          input logic [mstsched_pkg::FptrW-1:0] p);
      faddr = mstsched_pkg::FaddrW'(s * mstsched_pkg::FifoDepth + p);
   endfunction

   always_comb begin
      logic en, im;
      logic [31:0] w;
      state_in = state_ff; ret_in = ret_ff; req_in = req_ff; idx_in = idx_ff;
      cb_in = cb_ff; sr_in = sr_ff; el_in = el_ff; cnt_in = cnt_ff;
      inuse_in = inuse_ff; rp_in = rp_ff; wp_in = wp_ff; fill_in = fill_ff;
      rec_in = rec_ff; out_in = out_ff; outv_in = outv_ff;
      s_we = 1'b0; s_raddr = idx_ff; f_we = 1'b0; d_start = 1'b0;
      f_waddr = faddr(src, wp_ff[src]); f_raddr = faddr(src, rp_ff[src]);
      req_tready = 1'b0;
      en = cb_ff ? rec_ff.flags[3] : rec_ff.flags[1];
      im = cb_ff ? rec_ff.flags[4] : rec_ff.flags[2];
      w = cb_ff ? rec_ff.word1 : rec_ff.word0;
      f_wdata = {cb_ff, 3'(idx_ff), w, el_ff};
      if (outv_ff && rsp_tready) outv_in = 1'b0;
      case (state_ff)
         mstsched_pkg::S_IDLE: begin
            req_tready = !outv_ff;
            if (req_tvalid && !outv_ff) begin
               req_in = req_tdata; sr_in = 1'b0; idx_in = '0;
               out_in = '0; out_in.last = 1'b1;
               state_in = mstsched_pkg::S_OUT;
               case (req_tdata[2:0])
                  mstsched_pkg::OpTick:
                     if ({30'd0, req_tdata[4:3]} < mstsched_pkg::SourceCount) begin
                        cnt_in[req_tdata[4:3]] = cnt_ff[req_tdata[4:3]] + 64'd1;
                        state_in = mstsched_pkg::S_RD;
                     end else out_in.status = mstsched_pkg::StBadSlot;
                  mstsched_pkg::OpOpen, mstsched_pkg::OpDrain: state_in = mstsched_pkg::S_EVAL;
                  mstsched_pkg::OpStart, mstsched_pkg::OpStop,
                  mstsched_pkg::OpClose, mstsched_pkg::OpRead: begin
                     if ({29'd0, req_tdata[7:5]} < SlotCountFix
                         && inuse_ff[SW'(req_tdata[7:5])]) begin
                        idx_in = SW'(req_tdata[7:5]);
                        state_in = mstsched_pkg::S_RD;
                     end else out_in.status = mstsched_pkg::StBadSlot;
                  end
                  default: ;
               endcase
            end
         end
         mstsched_pkg::S_RD: begin
            state_in = mstsched_pkg::S_EVAL;
         end
         mstsched_pkg::S_EVAL: begin
            if (op == mstsched_pkg::OpOpen) begin
               state_in = mstsched_pkg::S_OUT;
               if (period == 32'd0 || !src_ok) out_in.status = mstsched_pkg::StBadPer;
               else if (!free_found) out_in.status = mstsched_pkg::StNoFree;
               else begin
                  idx_in = free_idx;
                  rec_in = '0; rec_in.in_use = 1'b1; rec_in.source = src;
                  rec_in.period = period; rec_in.flags = req_ff[44:40];
                  rec_in.word0 = req_ff[76:45]; rec_in.word1 = req_ff[108:77];
                  inuse_in[free_idx] = 1'b1;
                  out_in.slot = 3'(free_idx);
                  state_in = mstsched_pkg::S_WRITE; ret_in = mstsched_pkg::S_OUT;
               end
            end else if (op == mstsched_pkg::OpDrain) begin
               state_in = mstsched_pkg::S_OUT;
               if (!src_ok) out_in.status = mstsched_pkg::StBadSlot;
               else if (fill_ff[src] == '0) out_in.status = mstsched_pkg::StEmpty;
               else state_in = mstsched_pkg::S_DRD;
            end else if (op == mstsched_pkg::OpTick) begin
               rec_in = rec_rd;
               if (rec_rd.in_use && rec_rd.active && rec_rd.source == src) begin
                  rec_in.count = rec_rd.count + 32'd1;
                  ret_in = mstsched_pkg::S_RD;
                  if (rec_in.count >= rec_rd.period) begin
                     rec_in.count = '0;
                     d_start = 1'b1; cb_in = 1'b0;
                     state_in = mstsched_pkg::S_DIV;
                  end else state_in = mstsched_pkg::S_WRITE;
               end else if (idx_ff == SW'(SlotCountFix - 1)) begin
                  state_in = mstsched_pkg::S_OUT;
               end else begin
                  idx_in = idx_ff + SW'(1); state_in = mstsched_pkg::S_RD;
               end
            end else begin
               rec_in = rec_rd; d_start = 1'b1;
               out_in.slot = 3'(idx_ff);
               state_in = mstsched_pkg::S_DIV;
            end
         end
         mstsched_pkg::S_DIV: begin
            if (d_done) begin
               el_in = d_q;
               if (op == mstsched_pkg::OpTick) state_in = mstsched_pkg::S_CB;
               else begin
                  state_in = mstsched_pkg::S_WRITE; ret_in = mstsched_pkg::S_OUT;
                  case (op)
                     mstsched_pkg::OpStart: begin
                        rec_in.start = d_q; rec_in.active = 1'b1; rec_in.count = '0;
                     end
                     mstsched_pkg::OpStop: rec_in.active = 1'b0;
                     mstsched_pkg::OpClose: begin
                        rec_in = '0; inuse_in[idx_ff] = 1'b0;
                     end
                     default: begin
                        out_in.elapsed = d_q - rec_ff.start;
                        state_in = mstsched_pkg::S_OUT;
                     end
                  endcase
               end
            end
         end
         mstsched_pkg::S_CB: begin
            if (!outv_ff) begin
               if (en && im) begin
                  out_in = '0; out_in.kind = mstsched_pkg::KindImm;
                  out_in.slot = 3'(idx_ff); out_in.cb = cb_ff;
                  out_in.elapsed = el_ff; out_in.word = w; outv_in = 1'b1;
               end else if (en) begin
                  if (fill_ff[src] < mstsched_pkg::FillW'(mstsched_pkg::FifoDepth)) begin
                     f_we = 1'b1; sr_in = 1'b1;
                     wp_in[src] = (wp_ff[src] == mstsched_pkg::FptrW'(mstsched_pkg::FifoDepth - 1))
                                  ? '0 : wp_ff[src] + mstsched_pkg::FptrW'(1);
                     fill_in[src] = fill_ff[src] + mstsched_pkg::FillW'(1);
                  end else sr_in = 1'b0;
               end
               if (cb_ff) begin
                  if (rec_ff.flags[0]) rec_in.active = 1'b0;
                  state_in = mstsched_pkg::S_WRITE;
               end else cb_in = 1'b1;
            end
         end
         mstsched_pkg::S_WRITE: begin
            s_we = 1'b1;
            if (ret_ff == mstsched_pkg::S_OUT) state_in = mstsched_pkg::S_OUT;
            else if (idx_ff == SW'(SlotCountFix - 1)) begin
               state_in = mstsched_pkg::S_OUT;
            end else begin
               idx_in = idx_ff + SW'(1); state_in = mstsched_pkg::S_RD;
            end
         end
         mstsched_pkg::S_DRD: state_in = mstsched_pkg::S_DOUT;
         mstsched_pkg::S_DOUT: begin
            out_in.kind = mstsched_pkg::KindDrain;
            out_in.elapsed = f_rdata[63:0];
            out_in.word = f_rdata[95:64];
            out_in.slot = f_rdata[98:96];
            out_in.cb = f_rdata[99];
            rp_in[src] = (rp_ff[src] == mstsched_pkg::FptrW'(mstsched_pkg::FifoDepth - 1))
                         ? '0 : rp_ff[src] + mstsched_pkg::FptrW'(1);
            fill_in[src] = fill_ff[src] - mstsched_pkg::FillW'(1);
            state_in = mstsched_pkg::S_OUT;
         end
         mstsched_pkg::S_OUT: begin
            // the tick summary is built only once the last callback has left
            if (!outv_ff) begin
               if (op == mstsched_pkg::OpTick && src_ok) begin
                  out_in = '0; out_in.last = 1'b1; out_in.sr = sr_ff;
               end
               outv_in = 1'b1; state_in = mstsched_pkg::S_IDLE;
            end
         end
         default: state_in = mstsched_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mstsched_pkg::S_IDLE; ret_ff <= mstsched_pkg::S_IDLE;
         outv_ff <= 1'b0; inuse_ff <= '0;
         for (int i = 0; i < mstsched_pkg::SourceCount; i++) begin
            cnt_ff[i] <= '0; rp_ff[i] <= '0; wp_ff[i] <= '0; fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; outv_ff <= outv_in;
         inuse_ff <= inuse_in; cnt_ff <= cnt_in;
         rp_ff <= rp_in; wp_ff <= wp_in; fill_ff <= fill_in;
      end
      req_ff <= req_in; idx_ff <= idx_in; cb_ff <= cb_in; sr_ff <= sr_in;
      el_ff <= el_in; rec_ff <= rec_in; out_ff <= out_in;
   end

   assign rsp_tvalid = outv_ff;
   assign rsp_tlast = out_ff.last;
   assign rsp_tdata = {6'd0, out_ff.sr, out_ff.word, out_ff.elapsed, out_ff.cb,
                       out_ff.slot, out_ff.kind, out_ff.status};
endmodule

>>> sim/timer_scheduler_checker.sv
// Checker for the multiplexed soft timer scheduler: watches both streams,
// predicts every result transaction and compares it. Depends on mstsched_pkg.
`timescale 1ns / 1ps
module timer_scheduler_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending_count
);
   typedef struct {
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic        cb;
      logic [63:0] elapsed;
      logic [31:0] word;
      logic        sr;
      logic        last;
   } event_type;

   // scheduler shadow state
   logic [63:0] tick_count [mstsched_pkg::SourceCount];
   logic        in_use [mstsched_pkg::SlotCount];
   logic        active [mstsched_pkg::SlotCount];
   logic [1:0]  source [mstsched_pkg::SlotCount];
   logic [31:0] period [mstsched_pkg::SlotCount];
   logic [31:0] count [mstsched_pkg::SlotCount];
   logic [63:0] start_val [mstsched_pkg::SlotCount];
   logic [4:0]  flags [mstsched_pkg::SlotCount];
   logic [31:0] word0 [mstsched_pkg::SlotCount];
   logic [31:0] word1 [mstsched_pkg::SlotCount];
   logic [63:0] q_elapsed [mstsched_pkg::SourceCount][$];
   logic [35:0] q_tag [mstsched_pkg::SourceCount][$];
   event_type   expected_events [$];

   function automatic logic [63:0] scale(logic [63:0] c, logic [31:0] p);
      return (p != 0) ? c / {32'd0, p} : 64'd0;
   endfunction

   function automatic void push_event(logic [2:0] st, logic [1:0] k, logic [2:0] s,
                                      logic c, logic [63:0] el, logic [31:0] w,
                                      logic sr, logic l);
      event_type e;
      e.status = st; e.kind = k; e.slot = s; e.cb = c;
      e.elapsed = el; e.word = w; e.sr = sr; e.last = l;
      expected_events.push_back(e);
   endfunction

   function automatic void clear_slot(int s);
      in_use[s] = 0; active[s] = 0; source[s] = 0; period[s] = 0; count[s] = 0;
      start_val[s] = 0; flags[s] = 0; word0[s] = 0; word1[s] = 0;
   endfunction

   task automatic predict_request(logic [111:0] d);
      logic [2:0]  op;
      logic [1:0]  src;
      logic [2:0]  sl;
      logic [31:0] per;
      logic [63:0] el, v;
      logic [31:0] w;
      logic        sr;
      int          fs;
      op = d[2:0]; src = d[4:3]; sl = d[7:5]; per = d[39:8];
      case (op)
         mstsched_pkg::OpTick: begin
            if (src >= mstsched_pkg::SourceCount) begin
               push_event(mstsched_pkg::StBadSlot, mstsched_pkg::KindAck, 0, 0, 0, 0, 0, 1);
            end else begin
               sr = 0;
               tick_count[src]++;
               for (int s = 0; s < mstsched_pkg::SlotCount; s++) begin
                  if (!in_use[s] || source[s] != src || !active[s]) continue;
                  count[s]++;
                  if (count[s] < period[s]) continue;
                  count[s] = 0;
                  el = scale(tick_count[src], period[s]);
                  for (int c = 0; c < 2; c++) begin
                     w = c ? word1[s] : word0[s];
                     if (!flags[s][c ? 3 : 1]) continue;
                     if (flags[s][c ? 4 : 2]) begin
                        push_event(mstsched_pkg::StOk, mstsched_pkg::KindImm, s[2:0], c[0],
                                   el, w, 0, 0);
                     end else if (q_tag[src].size() >= mstsched_pkg::FifoDepth) begin
                        sr = 0;
                     end else begin
                        q_elapsed[src].push_back(el);
                        q_tag[src].push_back({c[0], s[2:0], w});
                        sr = 1;
                     end
                  end
                  if (flags[s][0]) active[s] = 0;
               end
               push_event(mstsched_pkg::StOk, mstsched_pkg::KindAck, 0, 0, 0, 0, sr, 1);
            end
         end
         mstsched_pkg::OpOpen: begin
            fs = -1;
            for (int s = mstsched_pkg::SlotCount - 1; s >= 0; s--) if (!in_use[s]) fs = s;
            if (per == 0 || src >= mstsched_pkg::SourceCount) begin
               push_event(mstsched_pkg::StBadPer, mstsched_pkg::KindAck, 0, 0, 0, 0, 0, 1);
            end else if (fs < 0) begin
               push_event(mstsched_pkg::StNoFree, mstsched_pkg::KindAck, 0, 0, 0, 0, 0, 1);
            end else begin
               clear_slot(fs);
               in_use[fs] = 1; source[fs] = src; period[fs] = per;
               flags[fs] = d[44:40]; word0[fs] = d[76:45]; word1[fs] = d[108:77];
               push_event(mstsched_pkg::StOk, mstsched_pkg::KindAck, 3'(fs), 0, 0, 0, 0, 1);
            end
         end
         mstsched_pkg::OpStart, mstsched_pkg::OpStop,
         mstsched_pkg::OpClose, mstsched_pkg::OpRead: begin
            if (!in_use[sl]) begin
               push_event(mstsched_pkg::StBadSlot, mstsched_pkg::KindAck, 0, 0, 0, 0, 0, 1);
            end else begin
               v = scale(tick_count[source[sl] % mstsched_pkg::SourceCount], period[sl]);
               el = 0;
               if (op == mstsched_pkg::OpStart) begin
                  start_val[sl] = v; active[sl] = 1; count[sl] = 0;
               end else if (op == mstsched_pkg::OpStop) begin
                  active[sl] = 0;
               end else if (op == mstsched_pkg::OpClose) begin
                  clear_slot(sl);
               end else begin
                  el = v - start_val[sl];
               end
               push_event(mstsched_pkg::StOk, mstsched_pkg::KindAck, sl, 0, el, 0, 0, 1);
            end
         end
         mstsched_pkg::OpDrain: begin
            if (src >= mstsched_pkg::SourceCount) begin
               push_event(mstsched_pkg::StBadSlot, mstsched_pkg::KindAck, 0, 0, 0, 0, 0, 1);
            end else if (q_tag[src].size() == 0) begin
               push_event(mstsched_pkg::StEmpty, mstsched_pkg::KindAck, 0, 0, 0, 0, 0, 1);
            end else begin
               logic [35:0] t;
               t = q_tag[src].pop_front();
               el = q_elapsed[src].pop_front();
               push_event(mstsched_pkg::StOk, mstsched_pkg::KindDrain, t[34:32], t[35], el,
                          t[31:0], 0, 1);
            end
         end
         default: push_event(mstsched_pkg::StOk, mstsched_pkg::KindAck, 0, 0, 0, 0, 0, 1);
      endcase
   endtask

   task automatic compare_result(logic [111:0] d, logic l);
      event_type e;
      if (expected_events.size() == 0) begin
         $error("result transaction with nothing expected: %h", d);
         fail_count++;
         return;
      end
      e = expected_events.pop_front();
      if (d[2:0] != e.status) begin
         $error("status expected %0d actual %0d", e.status, d[2:0]); fail_count++;
      end
      if (d[4:3] != e.kind) begin
         $error("kind expected %0d actual %0d", e.kind, d[4:3]); fail_count++;
      end
      if (d[7:5] != e.slot) begin
         $error("event_slot expected %0d actual %0d", e.slot, d[7:5]); fail_count++;
      end
      if (d[8] != e.cb) begin
         $error("callback_number expected %0d actual %0d", e.cb, d[8]); fail_count++;
      end
      if (d[72:9] != e.elapsed) begin
         $error("elapsed expected %0d actual %0d", e.elapsed, d[72:9]); fail_count++;
      end
      if (d[104:73] != e.word) begin
         $error("user_word expected %h actual %h", e.word, d[104:73]); fail_count++;
      end
      if (d[105] != e.sr) begin
         $error("service_request expected %0d actual %0d", e.sr, d[105]);
         fail_count++;
      end
      if (l != e.last) begin
         $error("last expected %0d actual %0d", e.last, l); fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      for (int i = 0; i < mstsched_pkg::SourceCount; i++) tick_count[i] = 0;
      for (int s = 0; s < mstsched_pkg::SlotCount; s++) clear_slot(s);
   end

   // results are compared before the same edge's request is predicted;
   // one item at a time means no result can depend on a request in flight
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) compare_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) predict_request(req_tdata);
      end
      pending_count = expected_events.size();
   end
endmodule

>>> sim/testbench.sv
// Top of the scheduler testbench: clock, reset, stimulus and verdict.
// Depends on mstsched_pkg, the scheduler top and timer_scheduler_checker.
`timescale 1ns / 1ps
module testbench;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [111:0] rsp_tdata;
   logic         rsp_tlast;
   int           fail_count, pending_count;
   longint       cycle_count = 0;
   logic         hold_off = 0;
   logic [111:0] stim_items [$];

   localparam longint CycleLimit = 4_000_000;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   multiplexed_soft_timer_scheduler_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   timer_scheduler_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   function automatic logic [111:0] make_item(logic [2:0] op, logic [1:0] src,
         logic [2:0] sl, logic [31:0] per, logic [4:0] fl, logic [31:0] w0,
         logic [31:0] w1);
      return {3'd0, w1, w0, fl, per, sl, src, op};
   endfunction

   function automatic logic [111:0] random_item();
      int r;
      logic [2:0] op;
      logic [31:0] per;
      logic [1:0] src;
      r = $urandom_range(0, 99);
      // mostly ticks on open short-period slots, sprinkled with controls
      if (r < 50) op = mstsched_pkg::OpTick;
      else if (r < 60) op = mstsched_pkg::OpOpen;
      else if (r < 70) op = mstsched_pkg::OpStart;
      else if (r < 76) op = mstsched_pkg::OpStop;
      else if (r < 82) op = mstsched_pkg::OpClose;
      else if (r < 88) op = mstsched_pkg::OpRead;
      else if (r < 98) op = mstsched_pkg::OpDrain;
      else op = 3'd7;
      r = $urandom_range(0, 19);
      per = (r == 0) ? $urandom() : (r == 1) ? 32'd0 : $urandom_range(1, 4);
      src = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      return make_item(op, src, 3'($urandom_range(0, 7)), per, 5'($urandom()),
                       $urandom(), $urandom());
   endfunction

   // receiver: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 0;
      else if (cycle_count % 3000 < 1500) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      hold_off = 0;
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_off = 1;
      repeat (4000) @(posedge clock);
      hold_off = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("multiplexed_soft_timer_scheduler_top: mismatch");
         $finish;
      end
   end

   initial begin
      logic [111:0] item;
      int gap;
      int burst;
      // directed: extremes, every operation, special cases
      stim_items.push_back(make_item(mstsched_pkg::OpTick, 3, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpDrain, 0, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpDrain, 3, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpStart, 0, 7, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpOpen, 0, 0, 0, 5'h1f, 1, 2));
      stim_items.push_back(make_item(mstsched_pkg::OpOpen, 3, 0, 5, 5'h1f, 1, 2));
      stim_items.push_back(make_item(mstsched_pkg::OpOpen, 0, 7, 1, 5'h1e, 32'hffffffff,
                                     32'h0));
      stim_items.push_back(make_item(mstsched_pkg::OpOpen, 1, 0, 32'hffffffff, 5'h1f, 0,
                                     32'hffffffff));
      stim_items.push_back(make_item(mstsched_pkg::OpOpen, 2, 0, 2, 5'h0a, 3, 4));
      stim_items.push_back(make_item(mstsched_pkg::OpOpen, 0, 0, 1, 5'h01, 5, 6));
      for (int i = 0; i < 3; i++)
         stim_items.push_back(make_item(mstsched_pkg::OpOpen, 0, 0, 1, 5'h0b, i, i));
      stim_items.push_back(make_item(mstsched_pkg::OpOpen, 0, 0, 3, 5'h1f, 9, 9));
      stim_items.push_back(make_item(mstsched_pkg::OpStart, 0, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpStart, 0, 1, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpStart, 0, 2, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpStart, 0, 4, 0, 0, 0, 0));
      for (int i = 0; i < 10; i++)
         stim_items.push_back(make_item(mstsched_pkg::OpTick, 0, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpRead, 0, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpStop, 0, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpDrain, 0, 0, 0, 0, 0, 0));
      stim_items.push_back(make_item(mstsched_pkg::OpClose, 0, 3, 0, 0, 0, 0));
      stim_items.push_back(make_item(3'd7, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 250; i++) stim_items.push_back(random_item());

      repeat (6) @(posedge clock);
      reset <= 0;
      while (stim_items.size() > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && stim_items.size() > 0) begin
            item = stim_items.pop_front();
            req_tdata <= item;
            req_tvalid <= 1;
            @(posedge clock iff req_tready);
            burst--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count > 0) @(posedge clock);
      repeat (700) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("multiplexed_soft_timer_scheduler_top: match");
      else
         $display("multiplexed_soft_timer_scheduler_top: mismatch");
      $finish;
   end
endmodule
